@@ rtl/core/qpp_pkg.sv @@
`default_nettype none

package qpp_pkg;

    localparam int COMP_BITS     = 16;
    localparam int FRAC_BITS     = 10;
    localparam int GAIN_BITS     = 16;
    localparam int TRIG_SHIFT    = 14;
    localparam int SINE_DEPTH    = 256;
    localparam int SINE_IDX_BITS = $clog2(SINE_DEPTH);
    localparam int ANGLE_BITS    = 16;
    localparam int CFG_BITS      = 48;
    localparam int CFG_IDX_BITS  = 3;

    // Widths of the lane arithmetic.
    localparam int ERR_BITS   = COMP_BITS + 1;
    localparam int PROD_BITS  = ERR_BITS + GAIN_BITS + 1;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int SUMSH_BITS = SUM_BITS - 8;
    localparam int INC_BITS   = PROD_BITS - 8;
    localparam int INTEG_BITS = GAIN_BITS + 2;
    localparam int FORCE_BITS = SUMSH_BITS + 1;
    localparam int TRIG_BITS  = 16;
    localparam int ROT_BITS   = FORCE_BITS + TRIG_BITS;
    localparam int MG_SHIFT   = 16 - FRAC_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_POSITION_GAIN  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VELOCITY_GAIN  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTEGRAL_GAIN  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VEHICLE_MASS   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRAVITY        = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTEGRAL_LIMIT = 3'd5;

    localparam logic [15:0] MASS_RESET  = 16'd128;
    localparam logic [15:0] GRAV_RESET  = 16'd2511;
    localparam logic [15:0] LIMIT_RESET = 16'd512;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [47:0] target_position;
        logic [47:0] target_velocity;
        logic [47:0] target_acceleration;
        logic [47:0] measured_position;
        logic [47:0] measured_velocity;
        logic [15:0] target_heading;
        logic [15:0] measured_heading;
        logic        clear_integrals;
    } qpp_in_t;

    typedef struct packed {
        logic signed [31:0] thrust;
        logic signed [31:0] roll_command;
        logic signed [31:0] pitch_command;
        logic [15:0]        heading_command;
    } qpp_out_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
        logic total;
    } qpp_lane_ctrl_t;

    typedef struct packed {
        logic trig;
        logic rot;
    } qpp_merge_ctrl_t;

    // Sine table entry in Q2.14, from a Taylor series in Q30.
    function automatic logic signed [TRIG_BITS-1:0] sine_entry(input int idx);
        longint unsigned a;
        longint unsigned q;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        a = ((64'(idx)) << 16) / SINE_DEPTH;
        a = a & 64'hFFFF;
        q = (a >> 14) & 64'd3;
        r = a & 64'h3FFF;
        if (q[0]) begin
            r = 64'd16384 - r;
        end
        x  = (r * HALF_PI_Q30) >> 14;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        s  = (s + (64'd1 << 15)) >> 16;
        if (s > 64'd16384) begin
            s = 64'd16384;
        end
        if (q >= 64'd2) begin
            return -TRIG_BITS'(s);
        end
        return TRIG_BITS'(s);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/qpp_axis_lane.sv @@
`default_nettype none

module qpp_axis_lane
    import qpp_pkg::*;
(
    input  wire                                aclk,
    input  wire                                aresetn,
    input  qpp_lane_ctrl_t                     ctrl,
    input  wire  [COMP_BITS-1:0]               tgt_pos,
    input  wire  [COMP_BITS-1:0]               tgt_vel,
    input  wire  [COMP_BITS-1:0]               tgt_acc,
    input  wire  [COMP_BITS-1:0]               meas_pos,
    input  wire  [COMP_BITS-1:0]               meas_vel,
    input  wire                                clear,
    input  wire  [GAIN_BITS-1:0]               kp,
    input  wire  [GAIN_BITS-1:0]               kv,
    input  wire  [GAIN_BITS-1:0]               ki,
    input  wire  [15:0]                        mass,
    input  wire  [15:0]                        limit,
    output logic signed [FORCE_BITS-1:0]       force_out
);

    logic signed [ERR_BITS-1:0]   ep_reg, ev_reg;
    logic signed [COMP_BITS-1:0]  acc_reg;
    logic                         clear_reg;
    logic signed [PROD_BITS-1:0]  pkp_reg, pkv_reg, pm_reg, pki_reg;
    logic signed [SUMSH_BITS-1:0] sum_sh_reg;
    logic signed [INTEG_BITS-1:0] integ_reg, integ_next;
    logic signed [FORCE_BITS-1:0] force_reg;

    logic signed [SUM_BITS-1:0]   sum;
    logic signed [INC_BITS-1:0]   inc;
    logic signed [INC_BITS:0]     integ_raw;
    logic signed [INC_BITS:0]     lim_pos;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            ep_reg    <= $signed({tgt_pos[COMP_BITS-1], tgt_pos})
                       - $signed({meas_pos[COMP_BITS-1], meas_pos});
            ev_reg    <= $signed({tgt_vel[COMP_BITS-1], tgt_vel})
                       - $signed({meas_vel[COMP_BITS-1], meas_vel});
            acc_reg   <= $signed(tgt_acc);
            clear_reg <= clear;
        end
        if (ctrl.mul) begin
            pkp_reg <= PROD_BITS'(ep_reg) * PROD_BITS'($signed({1'b0, kp}));
            pkv_reg <= PROD_BITS'(ev_reg) * PROD_BITS'($signed({1'b0, kv}));
            pki_reg <= PROD_BITS'(ep_reg) * PROD_BITS'($signed({1'b0, ki}));
            pm_reg  <= PROD_BITS'(acc_reg) * PROD_BITS'($signed({1'b0, mass}));
        end
        if (ctrl.acc) begin
            sum_sh_reg <= sum[SUM_BITS-1:8];
        end
        if (ctrl.total) begin
            force_reg <= FORCE_BITS'(integ_reg) + FORCE_BITS'(sum_sh_reg);
        end
    end

    always_comb begin
        sum = SUM_BITS'(pkp_reg) + SUM_BITS'(pkv_reg) + SUM_BITS'(pm_reg);
        inc = pki_reg[PROD_BITS-1:8];
        lim_pos = $signed({{(INC_BITS-15){1'b0}}, limit});
        // The integral only grows on an axis whose position gain is set.
        integ_raw = (clear_reg ? '0 : (INC_BITS+1)'(integ_reg))
                  + ((kp != '0) ? (INC_BITS+1)'(inc) : '0);
        if (integ_raw >= lim_pos) begin
            integ_next = INTEG_BITS'(lim_pos);
        end else if (integ_raw <= -lim_pos) begin
            integ_next = INTEG_BITS'(-lim_pos);
        end else begin
            integ_next = INTEG_BITS'(integ_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
        end else if (ctrl.acc) begin
            integ_reg <= integ_next;
        end
    end

    assign force_out = force_reg;

endmodule

`default_nettype wire

@@ rtl/core/qpp_merge.sv @@
`default_nettype none

module qpp_merge
    import qpp_pkg::*;
(
    input  wire                          aclk,
    input  qpp_merge_ctrl_t              ctrl,
    input  wire signed [FORCE_BITS-1:0]  fx,
    input  wire signed [FORCE_BITS-1:0]  fy,
    input  wire signed [FORCE_BITS-1:0]  fz,
    input  wire  [ANGLE_BITS-1:0]        heading,
    input  wire  [ANGLE_BITS-1:0]        heading_pass,
    input  wire  [15:0]                  mass,
    input  wire  [15:0]                  grav,
    output qpp_out_t                     result
);

    logic signed [TRIG_BITS-1:0] sine_rom [SINE_DEPTH];

    for (genvar gi = 0; gi < SINE_DEPTH; gi++) begin : g_rom
        assign sine_rom[gi] = sine_entry(gi);
    end

    logic [SINE_IDX_BITS-1:0]    sin_idx, cos_idx;
    logic signed [TRIG_BITS-1:0] sn_reg, cs_reg;
    logic signed [ROT_BITS-1:0]  xs_reg, xc_reg, ys_reg, yc_reg;
    logic [31:0]                 mg_reg;
    logic signed [ROT_BITS:0]    roll_sum, pitch_sum;

    assign sin_idx = heading[ANGLE_BITS-1 -: SINE_IDX_BITS];
    assign cos_idx = sin_idx + SINE_IDX_BITS'(SINE_DEPTH / 4);

    always_ff @(posedge aclk) begin
        if (ctrl.trig) begin
            sn_reg <= sine_rom[sin_idx];
            cs_reg <= sine_rom[cos_idx];
        end
        if (ctrl.rot) begin
            xs_reg <= ROT_BITS'(fx) * ROT_BITS'(sn_reg);
            xc_reg <= ROT_BITS'(fx) * ROT_BITS'(cs_reg);
            ys_reg <= ROT_BITS'(fy) * ROT_BITS'(sn_reg);
            yc_reg <= ROT_BITS'(fy) * ROT_BITS'(cs_reg);
            mg_reg <= mass * grav;
        end
    end

    // Forces stay within 2^28 and trig within 2^14 in magnitude, so none of
    // the outputs can leave the 32-bit range and no saturation is needed.
    always_comb begin
        roll_sum  = (ROT_BITS+1)'(xs_reg) - (ROT_BITS+1)'(yc_reg);
        pitch_sum = (ROT_BITS+1)'(xc_reg) + (ROT_BITS+1)'(ys_reg);
        result.roll_command    = 32'(roll_sum >>> TRIG_SHIFT);
        result.pitch_command   = 32'(pitch_sum >>> TRIG_SHIFT);
        result.thrust          = 32'(fz) + $signed({1'b0, mg_reg[31:MG_SHIFT]});
        result.heading_command = heading_pass;
    end

endmodule

`default_nettype wire

@@ rtl/core/quadrotor_position_pid_top.sv @@
// Channel   Ports                         Moves
// input     s_valid / s_ready / s_data    targets, measurements, headings, clear
// result    m_valid / m_ready / m_data    thrust, roll, pitch, heading
// config    cfg_wr_en / cfg_addr / cfg_wdata   register writes, no wait
//
// A transaction is accepted only in the idle step, so a new one is taken only
// after the result of the last has been registered. The six-step sequencer
// drives the three axis lanes and the rotation merge (difference, multiply,
// accumulate, force, rotate, sum). Reset is synchronous and active low; it
// clears the integrals, state, valid flag and gains and loads default mass,
// gravity and limit. A stalled result holds the sequencer in its last step.
`default_nettype none

module quadrotor_position_pid_top
    import qpp_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  qpp_in_t                 s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output qpp_out_t                m_data,
    input  wire                     cfg_wr_en,
    input  wire  [CFG_IDX_BITS-1:0] cfg_addr,
    input  wire  [CFG_BITS-1:0]     cfg_wdata
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_ACC   = 6'b000100,
        ST_FORCE = 6'b001000,
        ST_ROT   = 6'b010000,
        ST_SUM   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_BITS-1:0] kp_reg, kv_reg, ki_reg;
    logic [15:0]         mass_reg, grav_reg, limit_reg;
    logic [15:0]         head_reg, pass_reg;
    logic                m_valid_reg;
    qpp_out_t            m_data_reg;
    qpp_out_t            result;

    logic                accept, out_free;
    qpp_lane_ctrl_t      lane_ctrl;
    qpp_merge_ctrl_t     merge_ctrl;
    logic signed [FORCE_BITS-1:0] force_w [3];

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = ST_FORCE;
            ST_FORCE: state_next = ST_ROT;
            ST_ROT:   state_next = ST_SUM;
            ST_SUM:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        lane_ctrl.load   = accept;
        lane_ctrl.mul    = (state_reg == ST_MUL);
        lane_ctrl.acc    = (state_reg == ST_ACC);
        lane_ctrl.total  = (state_reg == ST_FORCE);
        merge_ctrl.trig  = (state_reg == ST_FORCE);
        merge_ctrl.rot   = (state_reg == ST_ROT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            kp_reg      <= '0;
            kv_reg      <= '0;
            ki_reg      <= '0;
            mass_reg    <= MASS_RESET;
            grav_reg    <= GRAV_RESET;
            limit_reg   <= LIMIT_RESET;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SUM && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_POSITION_GAIN:  kp_reg    <= cfg_wdata;
                    CFG_VELOCITY_GAIN:  kv_reg    <= cfg_wdata;
                    CFG_INTEGRAL_GAIN:  ki_reg    <= cfg_wdata;
                    CFG_VEHICLE_MASS:   mass_reg  <= cfg_wdata[15:0];
                    CFG_GRAVITY:        grav_reg  <= cfg_wdata[15:0];
                    CFG_INTEGRAL_LIMIT: limit_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            head_reg <= s_data.measured_heading;
            pass_reg <= s_data.target_heading;
        end
        if (state_reg == ST_SUM && out_free) begin
            m_data_reg <= result;
        end
    end

    for (genvar ax = 0; ax < 3; ax++) begin : g_lane
        qpp_axis_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (lane_ctrl),
            .tgt_pos   (s_data.target_position[ax*COMP_BITS +: COMP_BITS]),
            .tgt_vel   (s_data.target_velocity[ax*COMP_BITS +: COMP_BITS]),
            .tgt_acc   (s_data.target_acceleration[ax*COMP_BITS +: COMP_BITS]),
            .meas_pos  (s_data.measured_position[ax*COMP_BITS +: COMP_BITS]),
            .meas_vel  (s_data.measured_velocity[ax*COMP_BITS +: COMP_BITS]),
            .clear     (s_data.clear_integrals),
            .kp        (kp_reg[ax*GAIN_BITS +: GAIN_BITS]),
            .kv        (kv_reg[ax*GAIN_BITS +: GAIN_BITS]),
            .ki        (ki_reg[ax*GAIN_BITS +: GAIN_BITS]),
            .mass      (mass_reg),
            .limit     (limit_reg),
            .force_out (force_w[ax])
        );
    end

    qpp_merge u_merge (
        .aclk         (aclk),
        .ctrl         (merge_ctrl),
        .fx           (force_w[0]),
        .fy           (force_w[1]),
        .fz           (force_w[2]),
        .heading      (head_reg),
        .heading_pass (pass_reg),
        .mass         (mass_reg),
        .grav         (grav_reg),
        .result       (result)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_MUL)
        else $error("accepted transaction did not start the sequence");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM && m_valid_reg && !m_ready) |=> state_reg == ST_SUM)
        else $error("result left the sum step while the output was stalled");

    a_result_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid_reg) |-> $past(m_ready))
        else $error("result dropped without being taken");

endmodule

`default_nettype wire
